/* rtl/rcss_pkg.sv */
// Package for the rule-checked state stack: payload, command and state types.
package rcss_pkg;

	localparam int STATE_W     = 3;
	localparam int DEPTH_OUT_W = 5;
	localparam int RULE_W      = 64;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_IDX_W   = 1;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_RULE_MATRIX   = 1'b0;
	localparam cfg_idx_t CFG_INITIAL_STATE = 1'b1;

	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	typedef enum logic [1:0] {
		STAT_DONE     = 2'd0,
		STAT_BAD_MOVE = 2'd1,
		STAT_EMPTY    = 2'd2,
		STAT_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic               req_type;
		logic [STATE_W-1:0] new_state;
	} req_t;

	typedef struct packed {
		status_t                status;
		logic [STATE_W-1:0]     removed_state;
		logic [STATE_W-1:0]     current_state;
		logic [DEPTH_OUT_W-1:0] stack_depth;
	} res_t;

	typedef enum logic {
		CS_IDLE   = 1'b0,
		CS_REFILL = 1'b1
	} ctrl_state_t;

	typedef struct packed {
		logic exec;
		logic refill;
	} cmd_t;

	typedef struct packed {
		logic refill_needed;
	} sts_t;

endpackage

/* rtl/rcss_ctrl.sv */
// Controller: accepts requests and sequences the top-of-stack refill after a pop.
module rcss_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  rcss_pkg::sts_t sts,
	output rcss_pkg::cmd_t cmd,
	output logic          busy
);
	import rcss_pkg::*;

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			CS_IDLE: begin
				if (start && sts.refill_needed) begin
					state_d = CS_REFILL;
				end
			end
			CS_REFILL: begin
				state_d = CS_IDLE;
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b0;
		case (state_q)
			CS_IDLE: begin
				cmd.exec = start;
			end
			CS_REFILL: begin
				cmd.refill = 1'b1;
				busy       = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_refill_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == CS_REFILL |=> state_q == CS_IDLE)
		else $error("refill lasted more than one cycle");
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.exec && cmd.refill))
		else $error("exec and refill issued together");
	a_refill_follows_pop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.refill |-> $past(cmd.exec && sts.refill_needed))
		else $error("refill without a preceding pop");
`endif

endmodule

/* rtl/rcss_datapath.sv */
// Datapath: config registers, cached stack top, history memory and result register.
module rcss_datapath #(
	parameter int STACK_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  rcss_pkg::cfg_idx_t            cfg_idx,
	input  logic [rcss_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  rcss_pkg::req_t                req,
	input  rcss_pkg::cmd_t                cmd,
	output rcss_pkg::sts_t                sts,
	output logic                          done,
	output rcss_pkg::res_t                res
);
	import rcss_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	logic [RULE_W-1:0]  rule_q;
	logic [STATE_W-1:0] init_q;
	logic [CW-1:0]      count_q, count_d;
	logic [STATE_W-1:0] top_q, rd_q, rm_q;
	logic [STATE_W-1:0] mem [STACK_DEPTH];
	logic               done_q;
	res_t               res_q, res_d;

	logic [STATE_W-1:0] cur;
	logic               is_empty, is_full, rule_ok, push_ok, pop_ok, pop_refill, is_pop;

	always_comb begin
		is_empty   = (count_q == '0);
		is_full    = (count_q == CW'(STACK_DEPTH));
		cur        = is_empty ? init_q : top_q;
		rule_ok    = rule_q[{cur, req.new_state}];
		is_pop     = (req.req_type == REQ_POP);
		push_ok    = !is_pop && (is_empty || (rule_ok && !is_full));
		pop_ok     = is_pop && !is_empty;
		pop_refill = pop_ok && (count_q != CW'(1));
		sts.refill_needed = pop_refill;
	end

	always_comb begin
		count_d = count_q;
		res_d   = res_q;
		if (cmd.refill) begin
			res_d.status        = STAT_DONE;
			res_d.removed_state = rm_q;
			res_d.current_state = rd_q;
			res_d.stack_depth   = DEPTH_OUT_W'(count_q);
		end else if (cmd.exec) begin
			res_d.removed_state = '0;
			res_d.current_state = cur;
			if (!is_pop) begin
				if (push_ok) begin
					res_d.status        = STAT_DONE;
					res_d.current_state = req.new_state;
					count_d             = count_q + CW'(1);
				end else if (!rule_ok) begin
					res_d.status = STAT_BAD_MOVE;
				end else begin
					res_d.status = STAT_FULL;
				end
			end else if (pop_ok) begin
				res_d.status        = STAT_DONE;
				res_d.removed_state = top_q;
				res_d.current_state = init_q;
				count_d             = count_q - CW'(1);
			end else begin
				res_d.status = STAT_EMPTY;
			end
			res_d.stack_depth = DEPTH_OUT_W'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q  <= '0;
			init_q  <= '0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					CFG_RULE_MATRIX:   rule_q <= cfg_wdata[RULE_W-1:0];
					CFG_INITIAL_STATE: init_q <= cfg_wdata[STATE_W-1:0];
					default: begin
					end
				endcase
			end
			count_q <= count_d;
			// a pop that needs a refill reports after the refill cycle only
			done_q  <= (cmd.exec && !pop_refill) || cmd.refill;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (cmd.refill) begin
			top_q <= rd_q;
		end else if (cmd.exec && push_ok) begin
			top_q <= req.new_state;
		end
		if (cmd.exec && pop_ok) begin
			rm_q <= top_q;
		end
	end

	// entries below the cached top live in the memory
	always_ff @(posedge clk) begin
		if (cmd.exec && push_ok && !is_empty) begin
			mem[AW'(count_q - CW'(1))] <= top_q;
		end
		if (cmd.exec && pop_refill) begin
			rd_q <= mem[AW'(count_q - CW'(2))];
		end
	end

	assign done = done_q;
	assign res  = res_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= STACK_DEPTH)
		else $error("entry count beyond stack depth");
	a_refill_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.refill |-> !is_empty)
		else $error("refill with empty stack");
	a_fail_keeps_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec && !push_ok && !pop_ok |=> $stable(count_q))
		else $error("failed request changed the stack");
`endif

endmodule

/* rtl/rule_checked_state_stack_core.sv */
// Top level of the rule-checked state stack.
//
//  channel   handshake                 payload
//  request   start / busy              req (req_type, new_state)
//  result    done (one-cycle strobe)   res (status, removed_state, current_state, stack_depth)
//  config    cfg_we                    cfg_idx, cfg_wdata
//
// A push, a failed request or a pop emptying the stack skips the refill; busy stays low.
// A pop that leaves entries adds a refill step: the new top is read from the history memory
// (registered read port), and busy is high during that read.
// The result strobe is registered, the cycle after the last step of the request.
// Reset clears the count and config registers; the history memory is not cleared.
// The receiver cannot stall; each result is shown for exactly one cycle.
module rule_checked_state_stack_core #(
	parameter int STACK_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  rcss_pkg::req_t                req,
	output logic                          done,
	output rcss_pkg::res_t                res,
	input  logic                          cfg_we,
	input  rcss_pkg::cfg_idx_t            cfg_idx,
	input  logic [rcss_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import rcss_pkg::*;

	cmd_t cmd;
	sts_t sts;

	rcss_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	rcss_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.done      (done),
		.res       (res)
	);

`ifndef NO_ASSERTIONS
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy) || $past(busy))
		else $error("result without a request");
	a_fail_no_removed: assert property (@(posedge clk) disable iff (!arst_n)
		done && res.status != STAT_DONE |-> res.removed_state == '0)
		else $error("failed request reports a removed state");
	a_depth_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (STACK_DEPTH > 31) || (32'(res.stack_depth) <= STACK_DEPTH))
		else $error("reported depth beyond stack depth");
`endif

endmodule
